/* design/srrb_pkg.sv */
// Shared constants, types and the record program for the sample record ring buffer.
`default_nettype none

package srrb_pkg;

	localparam int BUFFER_DEPTH = 2048;
	localparam int PTR_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = 12;
	localparam int WORD_W       = 16;
	localparam int NUM_WORDS    = 10;
	localparam int IDX_W        = 4;
	localparam int RECORD_BYTES = 31;
	localparam int STEP_W       = 5;
	localparam int THRESH_RESET = 512;

	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	typedef enum logic [2:0] {
		SEL_HI,
		SEL_LO,
		SEL_COMMA,
		SEL_CR,
		SEL_LF
	} byte_sel_t;

	typedef struct packed {
		byte_sel_t        sel;
		logic [IDX_W-1:0] word_idx;
		logic             last;
	} rom_word_t;

	typedef struct packed {
		logic             active;
		byte_sel_t        sel;
		logic [IDX_W-1:0] word_idx;
		logic             last;
	} seq_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUT,
		ST_EMIT
	} state_t;

	function automatic rom_word_t cw(byte_sel_t sel, int idx, logic last);
		rom_word_t w;
		w.sel      = sel;
		w.word_idx = IDX_W'(idx);
		w.last     = last;
		return w;
	endfunction

	// One control word per byte of a record, in the order the bytes go out.
	function automatic rom_word_t record_rom(logic [STEP_W-1:0] step);
		rom_word_t w;
		case (step)
			5'd0:    w = cw(SEL_HI, 0, 1'b0);
			5'd1:    w = cw(SEL_LO, 0, 1'b0);
			5'd2:    w = cw(SEL_COMMA, 0, 1'b0);
			5'd3:    w = cw(SEL_HI, 1, 1'b0);
			5'd4:    w = cw(SEL_LO, 1, 1'b0);
			5'd5:    w = cw(SEL_COMMA, 1, 1'b0);
			5'd6:    w = cw(SEL_HI, 2, 1'b0);
			5'd7:    w = cw(SEL_LO, 2, 1'b0);
			5'd8:    w = cw(SEL_COMMA, 2, 1'b0);
			5'd9:    w = cw(SEL_HI, 3, 1'b0);
			5'd10:   w = cw(SEL_LO, 3, 1'b0);
			5'd11:   w = cw(SEL_COMMA, 3, 1'b0);
			5'd12:   w = cw(SEL_HI, 4, 1'b0);
			5'd13:   w = cw(SEL_LO, 4, 1'b0);
			5'd14:   w = cw(SEL_COMMA, 4, 1'b0);
			5'd15:   w = cw(SEL_HI, 5, 1'b0);
			5'd16:   w = cw(SEL_LO, 5, 1'b0);
			5'd17:   w = cw(SEL_COMMA, 5, 1'b0);
			5'd18:   w = cw(SEL_HI, 6, 1'b0);
			5'd19:   w = cw(SEL_LO, 6, 1'b0);
			5'd20:   w = cw(SEL_COMMA, 6, 1'b0);
			5'd21:   w = cw(SEL_HI, 7, 1'b0);
			5'd22:   w = cw(SEL_LO, 7, 1'b0);
			5'd23:   w = cw(SEL_COMMA, 7, 1'b0);
			5'd24:   w = cw(SEL_HI, 8, 1'b0);
			5'd25:   w = cw(SEL_LO, 8, 1'b0);
			5'd26:   w = cw(SEL_COMMA, 8, 1'b0);
			5'd27:   w = cw(SEL_HI, 9, 1'b0);
			5'd28:   w = cw(SEL_LO, 9, 1'b0);
			5'd29:   w = cw(SEL_CR, 9, 1'b0);
			5'd30:   w = cw(SEL_LF, 9, 1'b1);
			default: w = cw(SEL_LF, 9, 1'b1);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* design/srrb_if.sv */
// Handshake channels for the sample record ring buffer: request, response and threshold write.
`default_nettype none

interface srrb_req_if;
	import srrb_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [WORD_W-1:0] seq_word;
	logic [WORD_W-1:0] reading_1;
	logic [WORD_W-1:0] reading_2;
	logic [WORD_W-1:0] reading_3;
	logic [WORD_W-1:0] reading_4;
	logic [WORD_W-1:0] reading_5;
	logic [WORD_W-1:0] reading_6;
	logic [WORD_W-1:0] reading_7;
	logic [WORD_W-1:0] reading_8;
	logic [WORD_W-1:0] reading_9;
	modport source (output valid, op, seq_word, reading_1, reading_2, reading_3, reading_4,
		reading_5, reading_6, reading_7, reading_8, reading_9, input ready);
	modport sink (input valid, op, seq_word, reading_1, reading_2, reading_3, reading_4,
		reading_5, reading_6, reading_7, reading_8, reading_9, output ready);
endinterface

interface srrb_rsp_if;
	import srrb_pkg::*;
	logic             valid;
	logic             ready;
	logic             accepted;
	logic [7:0]       data_byte;
	logic             read_valid;
	logic [CNT_W-1:0] fill_count;
	logic             block_ready;
	modport source (output valid, accepted, data_byte, read_valid, fill_count, block_ready,
		input ready);
	modport sink (input valid, accepted, data_byte, read_valid, fill_count, block_ready,
		output ready);
endinterface

interface srrb_cfg_if;
	import srrb_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] block_threshold;
	modport source (output valid, block_threshold, input ready);
	modport sink (input valid, block_threshold, output ready);
endinterface

`default_nettype wire

/* design/srrb_seq.sv */
// Step counter and program table that sequence the byte writes of one record.
`default_nettype none

module srrb_seq
	import srrb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output seq_ctrl_t ctrl
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	rom_word_t         word;

	assign word = record_rom(step_q);

	always_comb begin
		ctrl.active   = busy_q;
		ctrl.sel      = word.sel;
		ctrl.word_idx = word.word_idx;
		ctrl.last     = word.last;
	end

	// The last control word jumps back to step zero and halts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (word.last) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/sample_record_ring_buffer.sv */
// Byte ring buffer fed with whole sample records and drained one byte per get item.
//
// Channels: req carries items (op 0 puts a record of ten 16-bit words, op 1 gets one
// byte); rsp returns one result item per request; cfg writes block_threshold.
// A put with room (fewer than depth minus 31 bytes held) stores 31 bytes: each word
// MSB then LSB, a comma after each of the first nine words, then CR and LF. A put
// without room is dropped whole. A get on an empty buffer returns zero, not valid.
// A stored put keeps req not ready after its acceptance while its 31 bytes are written
// through the single memory write port, paced by the record program, and until its
// result is posted to the output register, which can stall on rsp.ready. A get or a
// dropped put passes through the emit state, where its result is posted, and req stays
// not ready until that posting; a get reads the memory with a registered read.
// The result sits in an output register; the next item is accepted while it waits,
// and only the posting of a further result stalls until rsp.ready is seen.
// Reset clears pointers, fill count and the output valid and sets the threshold to
// 512. The memory contents are not cleared; no unwritten byte is ever read.
`default_nettype none

module sample_record_ring_buffer
	import srrb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	srrb_req_if.sink   req,
	srrb_rsp_if.source rsp,
	srrb_cfg_if.sink   cfg
);

	logic [7:0]        ring_mem [BUFFER_DEPTH];
	logic [WORD_W-1:0] words_q [NUM_WORDS];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  thresh_q;
	logic [7:0]        rd_data_q;
	logic              res_acc_q;
	logic              res_rd_q;
	logic              out_valid_q;
	logic              out_acc_q;
	logic [7:0]        out_data_q;
	logic              out_rd_q;
	logic [CNT_W-1:0]  out_fill_q;
	logic              out_blk_q;

	state_t            state_q;
	state_t            state_d;
	seq_ctrl_t         ctrl;
	logic              req_fire;
	logic              has_room;
	logic              is_put;
	logic              do_store;
	logic              do_pop;
	logic              seq_start;
	logic              emit_load;
	logic [WORD_W-1:0] cur_word;
	logic [7:0]        wr_byte;

	srrb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.ctrl   (ctrl)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign is_put    = (req.op == OP_PUT);
	assign has_room  = count_q < CNT_W'(BUFFER_DEPTH - RECORD_BYTES);
	assign do_store  = req_fire && is_put && has_room;
	assign do_pop    = req_fire && !is_put && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		seq_start = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (do_store) begin
						seq_start = 1'b1;
						state_d   = ST_PUT;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_PUT: begin
				if (ctrl.active && ctrl.last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					emit_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cur_word = words_q[ctrl.word_idx];

	always_comb begin
		case (ctrl.sel)
			SEL_HI:    wr_byte = cur_word[15:8];
			SEL_LO:    wr_byte = cur_word[7:0];
			SEL_COMMA: wr_byte = CHAR_COMMA;
			SEL_CR:    wr_byte = CHAR_CR;
			SEL_LF:    wr_byte = CHAR_LF;
			default:   wr_byte = CHAR_LF;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.active) begin
			ring_mem[wr_ptr_q] <= wr_byte;
		end
		if (do_pop) begin
			rd_data_q <= ring_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			res_acc_q <= do_store;
			res_rd_q  <= do_pop;
		end
		if (do_store) begin
			words_q[0] <= req.seq_word;
			words_q[1] <= req.reading_1;
			words_q[2] <= req.reading_2;
			words_q[3] <= req.reading_3;
			words_q[4] <= req.reading_4;
			words_q[5] <= req.reading_5;
			words_q[6] <= req.reading_6;
			words_q[7] <= req.reading_7;
			words_q[8] <= req.reading_8;
			words_q[9] <= req.reading_9;
		end
		if (emit_load) begin
			out_acc_q  <= res_acc_q;
			out_data_q <= res_rd_q ? rd_data_q : 8'h00;
			out_rd_q   <= res_rd_q;
			out_fill_q <= count_q;
			out_blk_q  <= (count_q >= thresh_q);
		end
	end

	// The fill count moves at acceptance; results are posted only after it settles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			thresh_q    <= CNT_W'(THRESH_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.active) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_store) begin
				count_q <= count_q + CNT_W'(RECORD_BYTES);
			end else if (do_pop) begin
				count_q  <= count_q - 1'b1;
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (cfg.valid && cfg.ready) begin
				thresh_q <= cfg.block_threshold;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.accepted    = out_acc_q;
	assign rsp.data_byte   = out_data_q;
	assign rsp.read_valid  = out_rd_q;
	assign rsp.fill_count  = out_fill_q;
	assign rsp.block_ready = out_blk_q;

endmodule

`default_nettype wire

/* design/srrb_check.sv */
// Port-level checker for the sample record ring buffer, bound to the top level.
`default_nettype none

module srrb_check
	import srrb_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic             rsp_accepted,
	input wire logic [7:0]       rsp_data_byte,
	input wire logic             rsp_read_valid,
	input wire logic [CNT_W-1:0] rsp_fill_count
);

	// A result is either a stored put or a popped byte, never both.
	a_acc_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_accepted && rsp_read_valid))
		else $error("result claims both a stored record and a popped byte");

	// Without a popped byte the data must read as zero.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_read_valid) |-> (rsp_data_byte == 8'h00))
		else $error("data byte nonzero on a result without a valid read");

	// The buffer never holds more than the depth less one byte.
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_fill_count < CNT_W'(BUFFER_DEPTH)))
		else $error("fill count out of range");

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_fill_count)))
		else $error("stalled result dropped or changed");

endmodule

bind sample_record_ring_buffer srrb_check u_srrb_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_accepted   (rsp.accepted),
	.rsp_data_byte  (rsp.data_byte),
	.rsp_read_valid (rsp.read_valid),
	.rsp_fill_count (rsp.fill_count)
);

`default_nettype wire
